FILE: design/vqdm_pkg.sv
// vqdm_pkg: shared types, constants and status codes for the virtqueue descriptor manager
// no dependencies

package vqdm_pkg;

   localparam int unsigned DefaultMaxQueue = 32;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_NO_ROOM  = 2'd1,
      STATUS_DROPPED  = 2'd2,
      STATUS_RETIRED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_ACTIVE = 2'd1,
      MODE_REJECT = 2'd2
   } chain_mode_type;

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_RETIRE = 1'b1
   } operation_type;

   typedef struct packed {
      logic        operation;
      logic        first_element;
      logic        last_element;
      logic [5:0]  chain_count;
      logic [63:0] buffer_address;
      logic [31:0] buffer_length;
      logic        device_writes;
      logic [4:0]  used_head;
      logic [31:0] used_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  descriptor_index;
      logic [4:0]  chain_start;
      logic        avail_published;
      logic [4:0]  avail_slot;
      logic [15:0] avail_index;
      logic [5:0]  freed_count;
      logic [31:0] completed_length;
      logic [4:0]  used_slot;
      logic [5:0]  free_total;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic rebuild;   // sweep the link table
      logic capture;   // latch the request
      logic decide;    // evaluate the request and update scalars
      logic walk;      // one chain step
      logic finish;    // close the retire and build the response
      logic publish;   // load the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rebuild_done;
      logic is_walk;
      logic walk_done;
   } sts_type;

endpackage

FILE: design/vqdm_datapath.sv
// vqdm_datapath: descriptor tables, free list, ring counters and chain walker
// depends on vqdm_pkg

module vqdm_datapath
   import vqdm_pkg::*;
#(
   parameter int unsigned MAX_QUEUE = DefaultMaxQueue
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_write,
   input  logic [5:0] csr_data,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_result
);

   localparam int unsigned IW = $clog2(MAX_QUEUE);
   localparam int unsigned SW = $clog2(MAX_QUEUE + 1);

   logic [SW-1:0] link_mem [MAX_QUEUE];
   logic          chained_mem [MAX_QUEUE];
   logic [63:0]   addr_mem [MAX_QUEUE];
   logic [31:0]   len_mem [MAX_QUEUE];
   logic          dev_mem [MAX_QUEUE];
   logic [4:0]    ring_mem [MAX_QUEUE];

   logic [SW-1:0] qsize_ff, qsize_in;
   logic [SW-1:0] free_first_ff, free_first_in;
   logic [SW-1:0] free_left_ff, free_left_in;
   logic [15:0]   avail_ff, avail_in;
   logic [15:0]   used_ff, used_in;
   logic [IW-1:0] prev_ff, prev_in;
   logic [IW-1:0] head_ff, head_in;
   chain_mode_type mode_ff, mode_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   req_type       req_ff;
   logic [IW-1:0] walk_idx_ff, walk_idx_in;
   logic [SW-1:0] walk_cnt_ff, walk_cnt_in;
   rsp_type       rsp_ff, rsp_in;
   rsp_type       out_ff;

   logic [6:0]    clamp_v;
   logic [SW-1:0] clamp_q;
   logic [SW-1:0] slot_calc;
   logic [SW-1:0] uslot_calc;
   logic [SW:0]   sum_calc;
   logic [SW-1:0] next_link;
   logic [IW-1:0] d_idx;
   logic          alloc_ok;
   logic          link_we;
   logic [IW-1:0] link_wa;
   logic [SW-1:0] link_wd;
   logic          chn_we;
   logic [IW-1:0] chn_wa;
   logic          chn_wd;
   logic          desc_we;
   logic          ring_we;
   logic          walk_more;
   logic          rebuilding;
   logic          walk_start;

   always_comb begin
      clamp_v = {1'b0, csr_data};
      if (clamp_v == 7'd0) begin
         clamp_q = SW'(1);
      end else if (32'(clamp_v) > MAX_QUEUE) begin
         clamp_q = SW'(MAX_QUEUE);
      end else begin
         clamp_q = SW'(clamp_v);
      end
   end

   // modulo by queue size: counter low bits are reduced by repeated subtract is too
   // deep, so the slot is tracked via a compare against the queue size and the counter wrap
   logic [SW-1:0] aslot_ff, aslot_in;
   logic [SW-1:0] uslot_ff, uslot_in;
   assign slot_calc  = aslot_ff;
   assign uslot_calc = uslot_ff;

   assign d_idx = free_first_ff[IW-1:0];
   assign next_link = link_mem[walk_idx_ff];
   assign sum_calc  = {1'b0, free_left_ff} + {1'b0, walk_cnt_ff};
   assign walk_more = chained_mem[walk_idx_ff] && (walk_cnt_ff < qsize_ff)
                      && (next_link < qsize_ff);
   assign rebuilding = (sweep_ff != SW'(MAX_QUEUE));
   assign walk_start = req_ff.operation == OP_RETIRE
                       && {1'b0, req_ff.used_head} < 6'(qsize_ff);

   assign sts.rebuild_done = !rebuilding;
   assign sts.is_walk      = walk_start;
   assign sts.walk_done    = !walk_more;

   always_comb begin
      qsize_in      = qsize_ff;
      free_first_in = free_first_ff;
      free_left_in  = free_left_ff;
      avail_in      = avail_ff;
      used_in       = used_ff;
      aslot_in      = aslot_ff;
      uslot_in      = uslot_ff;
      prev_in       = prev_ff;
      head_in       = head_ff;
      mode_in       = mode_ff;
      sweep_in      = sweep_ff;
      walk_idx_in   = walk_idx_ff;
      walk_cnt_in   = walk_cnt_ff;
      rsp_in        = rsp_ff;
      link_we = 1'b0; link_wa = '0; link_wd = '0;
      chn_we  = 1'b0; chn_wa  = '0; chn_wd  = 1'b0;
      desc_we = 1'b0; ring_we = 1'b0;
      alloc_ok = 1'b0;

      if (rebuilding) begin
         link_we  = 1'b1;
         link_wa  = sweep_ff[IW-1:0];
         link_wd  = sweep_ff + SW'(1);
         sweep_in = sweep_ff + SW'(1);
      end

      if (cmd.decide) begin
         rsp_in = '0;
         rsp_in.chain_start = 5'(head_ff);
         if (req_ff.operation == OP_RETIRE) begin
            rsp_in.chain_start = req_ff.used_head;
            if (!walk_start) begin
               rsp_in.status = STATUS_DROPPED;
            end
            walk_idx_in = IW'(req_ff.used_head);
            walk_cnt_in = SW'(1);
         end else begin
            priority if (req_ff.first_element
                         && 32'(free_left_ff) < 32'(req_ff.chain_count)) begin
               rsp_in.status = STATUS_NO_ROOM;
               mode_in = req_ff.last_element ? MODE_IDLE : MODE_REJECT;
            end else if (!req_ff.first_element && mode_ff != MODE_ACTIVE) begin
               rsp_in.status = STATUS_DROPPED;
               if (mode_ff == MODE_REJECT && req_ff.last_element) begin
                  mode_in = MODE_IDLE;
               end
            end else if (free_first_ff >= qsize_ff || free_left_ff == '0) begin
               rsp_in.status = STATUS_DROPPED;
               mode_in = req_ff.last_element ? MODE_IDLE : MODE_REJECT;
            end else begin
               alloc_ok = 1'b1;
            end
            if (alloc_ok) begin
               mode_in       = MODE_ACTIVE;
               free_first_in = link_mem[d_idx];
               link_we = 1'b1; link_wa = d_idx; link_wd = qsize_ff;
               free_left_in  = free_left_ff - SW'(1);
               desc_we = 1'b1;
               chn_we = 1'b1; chn_wa = d_idx; chn_wd = 1'b0;
               if (req_ff.first_element) begin
                  head_in = d_idx;
               end
               prev_in = d_idx;
               rsp_in.status = STATUS_ACCEPTED;
               rsp_in.descriptor_index = 5'(d_idx);
               rsp_in.chain_start = req_ff.first_element ? 5'(d_idx) : 5'(head_ff);
               if (req_ff.last_element) begin
                  ring_we = 1'b1;
                  rsp_in.avail_published = 1'b1;
                  rsp_in.avail_slot = 5'(slot_calc);
                  avail_in = avail_ff + 16'd1;
                  aslot_in = (avail_ff == 16'hFFFF || aslot_ff + SW'(1) == qsize_ff)
                             ? '0 : aslot_ff + SW'(1);
                  mode_in = MODE_IDLE;
               end
            end
         end
         rsp_in.avail_index = avail_in;
         rsp_in.free_total  = 6'(free_left_in);
      end

      if (cmd.walk && walk_more) begin
         walk_idx_in = next_link[IW-1:0];
         walk_cnt_in = walk_cnt_ff + SW'(1);
      end

      if (cmd.finish) begin
         link_we = 1'b1; link_wa = walk_idx_ff; link_wd = free_first_ff;
         free_first_in = SW'(req_ff.used_head);
         free_left_in  = (sum_calc > {1'b0, qsize_ff}) ? qsize_ff : sum_calc[SW-1:0];
         rsp_in.status = STATUS_RETIRED;
         rsp_in.freed_count = 6'(walk_cnt_ff);
         rsp_in.completed_length = req_ff.used_length;
         rsp_in.used_slot = 5'(uslot_calc);
         rsp_in.free_total = 6'(free_left_in);
         used_in  = used_ff + 16'd1;
         uslot_in = (used_ff == 16'hFFFF || uslot_ff + SW'(1) == qsize_ff)
                    ? '0 : uslot_ff + SW'(1);
      end

      if (csr_write) begin
         qsize_in = clamp_q;
         free_first_in = '0;
         free_left_in  = clamp_q;
         avail_in = '0; used_in = '0; aslot_in = '0; uslot_in = '0;
         prev_in = '0; head_in = '0; mode_in = MODE_IDLE;
         sweep_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qsize_ff      <= SW'(MAX_QUEUE < 32 ? MAX_QUEUE : 32);
         free_first_ff <= '0;
         free_left_ff  <= SW'(MAX_QUEUE < 32 ? MAX_QUEUE : 32);
         avail_ff <= '0; used_ff <= '0; aslot_ff <= '0; uslot_ff <= '0;
         prev_ff <= '0; head_ff <= '0; mode_ff <= MODE_IDLE;
         sweep_ff <= '0;
      end else begin
         qsize_ff <= qsize_in; free_first_ff <= free_first_in;
         free_left_ff <= free_left_in; avail_ff <= avail_in; used_ff <= used_in;
         aslot_ff <= aslot_in; uslot_ff <= uslot_in;
         prev_ff <= prev_in; head_ff <= head_in; mode_ff <= mode_in;
         sweep_ff <= sweep_in;
      end
      walk_idx_ff <= walk_idx_in;
      walk_cnt_ff <= walk_cnt_in;
      rsp_ff <= rsp_in;
      if (cmd.publish) begin
         out_ff <= rsp_ff;
      end
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // table writes
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (chn_we) begin
         chained_mem[chn_wa] <= chn_wd;
      end
      if (alloc_ok && !req_ff.first_element) begin
         link_mem[prev_ff] <= SW'(d_idx);
         chained_mem[prev_ff] <= 1'b1;
      end
      if (desc_we) begin
         addr_mem[d_idx] <= req_ff.buffer_address;
         len_mem[d_idx]  <= req_ff.buffer_length;
         dev_mem[d_idx]  <= req_ff.device_writes;
      end
      if (ring_we) begin
         ring_mem[slot_calc[IW-1:0]] <= 5'(head_in);
      end
   end

   assign rsp_result = out_ff;

`ifndef NO_ASSERTIONS
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_left_ff <= qsize_ff) else $error("free count above queue size");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      aslot_ff < qsize_ff && uslot_ff < qsize_ff) else $error("ring slot out of range");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> walk_cnt_ff <= qsize_ff) else $error("walk overran queue");
`endif

endmodule

FILE: design/vqdm_control.sv
// vqdm_control: sequencing of capture, decision, chain walk and response hand-off
// depends on vqdm_pkg

module vqdm_control
   import vqdm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_write,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECIDE, ST_WALK, ST_FINISH, ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign req_stall = !(state_ff == ST_IDLE && sts.rebuild_done && !csr_write);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cmd = '0;
      cmd.rebuild = !sts.rebuild_done;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.capture = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = sts.is_walk ? ST_WALK : ST_RESPOND;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.publish = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.decide, cmd.walk, cmd.finish}))
      else $error("overlapping commands");
   a_decide_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.decide) else $error("capture not followed by decide");
   a_finish_after_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> $past(cmd.walk)) else $error("finish without walk");
`endif

endmodule

FILE: design/virtqueue_descriptor_manager.sv
// virtqueue_descriptor_manager: top level, one split virtqueue
// depends on vqdm_pkg, vqdm_control, vqdm_datapath
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req_data (req_type)
//   result  | rsp_valid | rsp_stall | rsp_data (rsp_type)
//   config  | csr_write | -         | csr_data
//
// add request and dropped retire: capture, decide and respond; retire: capture, decide,
// a walk of the link table one step a cycle, then finish and respond
// reset and csr writes sweep all MAX_QUEUE entries of the link table, requests stalled
// the output register holds while rsp_stall is high; the next request is taken and
// waits for its response slot

module virtqueue_descriptor_manager
   import vqdm_pkg::*;
#(
   parameter int unsigned MAX_QUEUE = DefaultMaxQueue
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [5:0] csr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   cmd_type cmd;
   sts_type sts;

   vqdm_control u_control (
      .clock, .reset, .csr_write, .req_valid, .req_stall,
      .rsp_valid, .rsp_stall, .sts, .cmd
   );

   vqdm_datapath #(.MAX_QUEUE(MAX_QUEUE)) u_datapath (
      .clock, .reset, .csr_write, .csr_data, .req_data, .cmd, .sts,
      .rsp_result(rsp_data)
   );

endmodule
